### rtl/core/mpfd_pkg.sv
// Shared constants, command codes and controller/datapath interface types
// for the monochrome page frame store drawing block. No dependencies.
package mpfd_pkg;

    localparam int COLUMNS = 128;
    localparam int PAGES   = 8;
    localparam int DEPTH   = COLUMNS * PAGES;
    localparam int ADDR_W  = $clog2(DEPTH);

    localparam logic [2:0] MODE_SET   = 3'd0;
    localparam logic [2:0] MODE_CLR   = 3'd1;
    localparam logic [2:0] MODE_LINE  = 3'd2;
    localparam logic [2:0] MODE_CIRC  = 3'd3;
    localparam logic [2:0] MODE_WIPE  = 3'd4;
    localparam logic [2:0] MODE_READ  = 3'd5;

    // point source for a pixel read-modify-write
    localparam logic [1:0] SRC_IN  = 2'd0;
    localparam logic [1:0] SRC_LV  = 2'd1;
    localparam logic [1:0] SRC_LH  = 2'd2;
    localparam logic [1:0] SRC_CIR = 2'd3;

    typedef struct packed {
        logic       cap;        // capture the input item
        logic       clr_init;   // restart the wipe sweep
        logic       clr_step;   // write zero, advance sweep
        logic       lv_init;    // start vertical run
        logic       lh_init;    // start horizontal run
        logic       line_step;  // advance run index
        logic       cir_init;   // load a, b and squares
        logic       cir_pt;     // advance octant index
        logic       cir_step;   // advance a or b
        logic       pt_rd;      // latch point, read its byte
        logic [1:0] pt_src;
        logic       pt_on;      // set (1) or clear (0)
        logic       pt_wr;      // write modified byte
        logic       byte_rd;    // read byte for a read command
        logic       out_load;   // load output register
    } t_cmd;

    typedef struct packed {
        logic [2:0] mode;
        logic       clr_last;
        logic       line_done;
        logic       cir_zero;
        logic       cir_cont;
        logic       cir_k_last;
        logic       cir_break;
        logic       out_free;
    } t_stat;

endpackage

### rtl/core/mpfd_ctrl.sv
// Controller state machine for the frame store drawing block.
// Depends on mpfd_pkg; drives t_cmd to mpfd_dp and reads t_stat back.
module mpfd_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  mpfd_pkg::t_stat i_stat,
    output mpfd_pkg::t_cmd  o_cmd
);
    import mpfd_pkg::*;

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_PWR   = 4'd3;
    localparam logic [3:0] S_LV    = 4'd4;
    localparam logic [3:0] S_LH    = 4'd5;
    localparam logic [3:0] S_CCHK  = 4'd6;
    localparam logic [3:0] S_CPT   = 4'd7;
    localparam logic [3:0] S_CSTEP = 4'd8;
    localparam logic [3:0] S_RWAIT = 4'd9;

    logic [3:0] r_state, n_state;
    logic [3:0] r_ret, n_ret;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.cap = 1'b1;
                    n_state   = S_DISP;
                end
            end
            S_DISP: begin
                case (i_stat.mode)
                    MODE_SET, MODE_CLR: begin
                        o_cmd.pt_rd  = 1'b1;
                        o_cmd.pt_src = SRC_IN;
                        o_cmd.pt_on  = (i_stat.mode == MODE_SET);
                        n_ret        = S_IDLE;
                        n_state      = S_PWR;
                    end
                    MODE_LINE: begin
                        o_cmd.lv_init = 1'b1;
                        n_state       = S_LV;
                    end
                    MODE_CIRC: begin
                        o_cmd.cir_init = 1'b1;
                        n_state        = S_CCHK;
                    end
                    MODE_WIPE: begin
                        o_cmd.clr_init = 1'b1;
                        n_state        = S_CLR;
                    end
                    MODE_READ: begin
                        o_cmd.byte_rd = 1'b1;
                        n_state       = S_RWAIT;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_PWR: begin
                o_cmd.pt_wr = 1'b1;
                n_state     = r_ret;
            end
            S_LV: begin
                if (i_stat.line_done) begin
                    o_cmd.lh_init = 1'b1;
                    n_state       = S_LH;
                end else begin
                    o_cmd.pt_rd     = 1'b1;
                    o_cmd.pt_src    = SRC_LV;
                    o_cmd.pt_on     = 1'b1;
                    o_cmd.line_step = 1'b1;
                    n_ret           = S_LV;
                    n_state         = S_PWR;
                end
            end
            S_LH: begin
                if (i_stat.line_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.pt_rd     = 1'b1;
                    o_cmd.pt_src    = SRC_LH;
                    o_cmd.pt_on     = 1'b1;
                    o_cmd.line_step = 1'b1;
                    n_ret           = S_LH;
                    n_state         = S_PWR;
                end
            end
            S_CCHK: begin
                if (i_stat.cir_zero) begin
                    o_cmd.pt_rd  = 1'b1;
                    o_cmd.pt_src = SRC_IN;
                    o_cmd.pt_on  = 1'b1;
                    n_ret        = S_IDLE;
                    n_state      = S_PWR;
                end else if (i_stat.cir_cont) begin
                    n_state = S_CPT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_CPT: begin
                o_cmd.pt_rd  = 1'b1;
                o_cmd.pt_src = SRC_CIR;
                o_cmd.pt_on  = 1'b1;
                o_cmd.cir_pt = 1'b1;
                n_ret        = i_stat.cir_k_last ? S_CSTEP : S_CPT;
                n_state      = S_PWR;
            end
            S_CSTEP: begin
                o_cmd.cir_step = 1'b1;
                n_state        = i_stat.cir_break ? S_IDLE : S_CCHK;
            end
            S_RWAIT: begin
                // hold the byte until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/core/mpfd_dp.sv
// Datapath: frame store memory, point generators for lines and circles,
// pixel read-modify-write and the output register. Depends on mpfd_pkg.
module mpfd_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [2:0]      i_mode,
    input  logic [39:0]     i_data,
    input  mpfd_pkg::t_cmd  i_cmd,
    output mpfd_pkg::t_stat o_stat,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output logic [7:0]      o_m_tdata
);
    import mpfd_pkg::*;

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    logic [2:0] r_mode;
    logic [7:0] r_px, r_py, r_qx, r_qy, r_radius;

    logic [ADDR_W-1:0] r_ccnt;
    logic [7:0]        r_i, r_hi;
    logic [7:0]        r_a, r_b;
    logic [17:0]       r_aa, r_bb;
    logic [15:0]       r_rr;
    logic [2:0]        r_k;

    logic [7:0]        r_x, r_y;
    logic              r_on, r_inb;
    logic              r_rd_ok;
    logic              r_m_valid;
    logic [7:0]        r_m_data;

    logic [7:0]        pt_x, pt_y;
    logic [4:0]        pt_page;
    logic              pt_inb;
    logic [ADDR_W-1:0] pt_addr, x_addr, rd_addr;
    logic              rd_ok;
    logic [15:0]       sq;
    logic [17:0]       aa_n, bb_n;
    logic              a_over;
    logic [7:0]        bitm, wdata;

    // point selection
    always_comb begin
        pt_x = r_px;
        pt_y = r_py;
        case (i_cmd.pt_src)
            SRC_IN: begin
                pt_x = r_px;
                pt_y = r_py;
            end
            SRC_LV: begin
                pt_x = r_qx;
                pt_y = r_i;
            end
            SRC_LH: begin
                pt_x = r_i;
                pt_y = r_qy;
            end
            SRC_CIR: begin
                case (r_k)
                    3'd0: begin pt_x = r_px + r_a; pt_y = r_py - r_b; end
                    3'd1: begin pt_x = r_px - r_a; pt_y = r_py - r_b; end
                    3'd2: begin pt_x = r_px - r_a; pt_y = r_py + r_b; end
                    3'd3: begin pt_x = r_px + r_a; pt_y = r_py + r_b; end
                    3'd4: begin pt_x = r_px + r_b; pt_y = r_py + r_a; end
                    3'd5: begin pt_x = r_px + r_b; pt_y = r_py - r_a; end
                    3'd6: begin pt_x = r_px - r_b; pt_y = r_py - r_a; end
                    default: begin pt_x = r_px - r_b; pt_y = r_py + r_a; end
                endcase
            end
            default: ;
        endcase
    end

    assign pt_page = pt_y[7:3];
    assign pt_inb  = ({1'b0, pt_x} < 9'(COLUMNS)) && (32'(pt_page) < PAGES);
    assign pt_addr = ADDR_W'(pt_x) * ADDR_W'(PAGES) + ADDR_W'(pt_page);
    assign rd_ok   = ({1'b0, r_px} < 9'(COLUMNS)) && (32'(r_py) < PAGES);
    assign x_addr  = ADDR_W'(r_px) * ADDR_W'(PAGES) + ADDR_W'(r_py);
    assign rd_addr = i_cmd.byte_rd ? x_addr : pt_addr;

    assign sq     = 16'(r_radius) * 16'(r_radius);
    assign aa_n   = r_aa + 18'({r_a, 1'b0}) + 18'd1;
    assign bb_n   = r_bb - 18'({r_b, 1'b0}) + 18'd1;
    assign a_over = (aa_n + r_bb) > 18'(r_rr);

    assign bitm  = 8'(1) << r_y[2:0];
    assign wdata = r_on ? (r_rdata | bitm) : (r_rdata & ~bitm);

    // store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem[r_ccnt] <= '0;
        end else if (i_cmd.pt_wr && r_inb) begin
            mem[ADDR_W'(r_x) * ADDR_W'(PAGES) + ADDR_W'(r_y[7:3])] <= wdata;
        end
        if (i_cmd.pt_rd || i_cmd.byte_rd) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ccnt    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_init) r_ccnt <= '0;
            else if (i_cmd.clr_step) r_ccnt <= r_ccnt + ADDR_W'(1);
            if (i_cmd.out_load) r_m_valid <= 1'b1;
            else if (i_m_tready) r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_mode   <= i_mode;
            r_px     <= i_data[7:0];
            r_py     <= i_data[15:8];
            r_qx     <= i_data[23:16];
            r_qy     <= i_data[31:24];
            r_radius <= i_data[39:32];
        end
        if (i_cmd.lv_init) begin
            r_i  <= (r_py < r_qy) ? r_py : r_qy;
            r_hi <= (r_py < r_qy) ? r_qy : r_py;
        end else if (i_cmd.lh_init) begin
            r_i  <= (r_px < r_qx) ? r_px : r_qx;
            r_hi <= (r_px < r_qx) ? r_qx : r_px;
        end else if (i_cmd.line_step) begin
            r_i <= r_i + 8'd1;
        end
        if (i_cmd.cir_init) begin
            r_a  <= '0;
            r_b  <= r_radius;
            r_aa <= '0;
            r_bb <= 18'(sq);
            r_rr <= sq;
            r_k  <= '0;
        end else begin
            if (i_cmd.cir_pt) r_k <= r_k + 3'd1;
            if (i_cmd.cir_step) begin
                if (!a_over) begin
                    r_a  <= r_a + 8'd1;
                    r_aa <= aa_n;
                end else if (r_b != 8'd0) begin
                    r_b  <= r_b - 8'd1;
                    r_bb <= bb_n;
                end
            end
        end
        if (i_cmd.pt_rd) begin
            r_x   <= pt_x;
            r_y   <= pt_y;
            r_on  <= i_cmd.pt_on;
            r_inb <= pt_inb;
        end
        if (i_cmd.byte_rd) r_rd_ok <= rd_ok;
        if (i_cmd.out_load) r_m_data <= r_rd_ok ? r_rdata : 8'd0;
    end

    assign o_stat.mode       = r_mode;
    assign o_stat.clr_last   = (32'(r_ccnt) == DEPTH - 1);
    assign o_stat.line_done  = (r_i >= r_hi);
    assign o_stat.cir_zero   = (r_radius == 8'd0);
    assign o_stat.cir_cont   = ({r_bb[16:0], 1'b0} >= 18'(r_rr));
    assign o_stat.cir_k_last = (r_k == 3'd7);
    assign o_stat.cir_break  = a_over && (r_b == 8'd0);
    assign o_stat.out_free   = !r_m_valid || i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    a_aa_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cir_step |=> r_aa == 18'(r_a) * 18'(r_a))
        else $error("a squared tracker out of step");
    a_bb_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cir_step |=> r_bb == 18'(r_b) * 18'(r_b))
        else $error("b squared tracker out of step");
    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pt_wr |-> $past(i_cmd.pt_rd))
        else $error("pixel write without a preceding read");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_m_valid || i_m_tready))
        else $error("output register overwritten while held");

endmodule

### rtl/core/mono_page_framebuffer_draw.sv
// Top level of the monochrome page frame store drawing block.
// Depends on mpfd_pkg, mpfd_ctrl and mpfd_dp.
//
// Commands arrive on the slave stream: the mode rides in tuser, the
// coordinates and radius in tdata. One command is taken at a time; tready
// is high only while the block is idle. Set and clear pixel do one
// read-modify-write of a store byte before ready returns. An L-line plots
// a vertical run and then a horizontal run, one read-modify-write per
// position, dropped pixels included; a circle does one read-modify-write
// per plotted point, eight points per (a, b) step. Clear store sweeps all
// 1024 bytes, one per cycle. A read byte command returns its byte on the
// master stream through the registered store read and the output register;
// the output register keeps the byte while the receiver stalls, and the next
// read waits until it is taken, while other commands go on.
// After reset the same clearing sweep of all 1024 bytes runs with tready low.
module mono_page_framebuffer_draw (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [2:0]  i_s_tuser,   // [2:0] mode
    input  logic [39:0] i_s_tdata,   // [7:0] px, [15:8] py, [23:16] qx,
                                     // [31:24] qy, [39:32] radius
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata    // [7:0] read_byte
);
    import mpfd_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    mpfd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mpfd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mode     (i_s_tuser),
        .i_data     (i_s_tdata),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
